/* hdl/weighted_vector_gram_accumulator_core_macros.svh */
// Assertion macros for the weighted vector Gram accumulator.
// Included by the top level; depends on nothing else.
`ifndef WEIGHTED_VECTOR_GRAM_ACCUMULATOR_CORE_MACROS_SVH
`define WEIGHTED_VECTOR_GRAM_ACCUMULATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define WVGA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define WVGA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wvga_pkg.sv */
// Shared types, widths and term tables for the weighted vector Gram accumulator.
// No dependencies; used by wvga_term_unit and the top level.
package wvga_pkg;

    localparam int COMP_W     = 24;
    localparam int VEC_W      = 3 * COMP_W;
    localparam int WT_W       = 24;
    localparam int IDX_W      = 6;
    localparam int OP_W       = 2;
    localparam int PC_W       = 7;
    localparam int OUT_W      = 40;
    localparam int TERM_W     = 32;
    localparam int PROD_W     = 2 * COMP_W;
    localparam int NUM_SUMS   = 6;
    localparam int N_TERMS    = 9;
    localparam int TIDX_W     = 4;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = NUM_SUMS * OUT_W;

    localparam logic [PC_W-1:0] PC_RESET = 7'd64;

    localparam logic signed [OUT_W-1:0] SAT_HI = 40'sh7F_FFFF_FFFF;
    localparam logic signed [OUT_W-1:0] SAT_LO = 40'sh80_0000_0000;

    // Operation codes carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_WR_BASIS  = 2'd0,
        OP_WR_WEIGHT = 2'd1,
        OP_QUERY     = 2'd2
    } op_t;

    // Component select codes
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // Request to the shared term unit
    typedef struct packed {
        logic                     valid;
        logic signed [COMP_W-1:0] c;
        logic signed [COMP_W-1:0] d;
        logic [WT_W-1:0]          w;
    } term_req_t;

    // Status back from the term unit
    typedef struct packed {
        logic busy;
        logic done;
    } term_sts_t;

    // Component of vector i used by each term
    function automatic logic [1:0] term_src_i(input logic [TIDX_W-1:0] t);
        logic [1:0] r;
        unique case (t)
            4'd0, 4'd3, 4'd5: r = COMP_X;
            4'd1, 4'd4, 4'd7: r = COMP_Y;
            4'd2, 4'd6, 4'd8: r = COMP_Z;
            default:          r = COMP_X;
        endcase
        return r;
    endfunction

    // Component of vector j used by each term
    function automatic logic [1:0] term_src_j(input logic [TIDX_W-1:0] t);
        logic [1:0] r;
        unique case (t)
            4'd0, 4'd4, 4'd6: r = COMP_X;
            4'd1, 4'd3, 4'd8: r = COMP_Y;
            4'd2, 4'd5, 4'd7: r = COMP_Z;
            default:          r = COMP_X;
        endcase
        return r;
    endfunction

    // Sum that each term lands in: xx, yy, zz, xy, xz, yz
    function automatic logic [2:0] term_dst(input logic [TIDX_W-1:0] t);
        logic [2:0] r;
        unique case (t)
            4'd0:       r = 3'd0;
            4'd1:       r = 3'd1;
            4'd2:       r = 3'd2;
            4'd3, 4'd4: r = 3'd3;
            4'd5, 4'd6: r = 3'd4;
            4'd7, 4'd8: r = 3'd5;
            default:    r = 3'd0;
        endcase
        return r;
    endfunction

    // Magnitude of a two's complement component; the most negative value fits
    function automatic logic [COMP_W-1:0] comp_abs(input logic signed [COMP_W-1:0] v);
        logic [COMP_W-1:0] r;
        r = v[COMP_W-1] ? COMP_W'(-v) : COMP_W'(v);
        return r;
    endfunction

endpackage

/* hdl/wvga_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the basis vectors and the weights.
module wvga_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4096
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/wvga_term_unit.sv */
// Shared weighted-product unit: one 24x24 multiplier used three times per term.
// Depends on wvga_pkg. Returns trunc(c * d * w / 2^40) toward zero.
module wvga_term_unit
    import wvga_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  term_req_t                req,
    output term_sts_t                sts,
    output logic signed [TERM_W-1:0] term
);

    typedef enum logic [4:0] {
        TS_IDLE = 5'b00001,
        TS_PROD = 5'b00010,
        TS_LO   = 5'b00100,
        TS_HI   = 5'b01000,
        TS_FIN  = 5'b10000
    } tstate_t;

    tstate_t                   state_reg, state_next;
    logic                      done_reg, done_next;
    logic [COMP_W-1:0]         mag_c_reg, mag_c_next;
    logic [COMP_W-1:0]         mag_d_reg, mag_d_next;
    logic [WT_W-1:0]           w_reg, w_next;
    logic                      neg_reg, neg_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [COMP_W-1:0]         lo_reg, lo_next;
    logic signed [TERM_W-1:0]  term_reg, term_next;

    logic [COMP_W-1:0]         mul_a, mul_b;
    logic [PROD_W-1:0]         mul_p;
    logic [PROD_W-1:0]         fin_sum;
    logic [TERM_W-1:0]         fin_mag;

    // Shared multiplier operand select
    always_comb begin
        unique case (state_reg)
            TS_PROD: begin
                mul_a = mag_c_reg;
                mul_b = mag_d_reg;
            end
            TS_LO: begin
                mul_a = prod_reg[COMP_W-1:0];
                mul_b = w_reg;
            end
            TS_HI: begin
                mul_a = prod_reg[PROD_W-1:COMP_W];
                mul_b = w_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // High partial product plus carry-in from the low one, scaled by 2^-40
    assign fin_sum = prod_reg + PROD_W'(lo_reg);
    assign fin_mag = fin_sum[PROD_W-1:PROD_W-TERM_W];

    // Sequencer
    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        mag_c_next = mag_c_reg;
        mag_d_next = mag_d_reg;
        w_next     = w_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        lo_next    = lo_reg;
        term_next  = term_reg;
        unique case (state_reg)
            TS_IDLE: begin
                if (req.valid) begin
                    mag_c_next = comp_abs(req.c);
                    mag_d_next = comp_abs(req.d);
                    neg_next   = req.c[COMP_W-1] ^ req.d[COMP_W-1];
                    w_next     = req.w;
                    state_next = TS_PROD;
                end
            end
            TS_PROD: begin
                prod_next  = mul_p;
                state_next = TS_LO;
            end
            TS_LO: begin
                lo_next    = mul_p[PROD_W-1:COMP_W];
                state_next = TS_HI;
            end
            TS_HI: begin
                prod_next  = mul_p;
                state_next = TS_FIN;
            end
            TS_FIN: begin
                term_next  = neg_reg ? -$signed(fin_mag) : $signed(fin_mag);
                done_next  = 1'b1;
                state_next = TS_IDLE;
            end
            default: begin
                state_next = TS_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        mag_c_reg <= mag_c_next;
        mag_d_reg <= mag_d_next;
        w_reg     <= w_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
        lo_reg    <= lo_next;
        term_reg  <= term_next;
    end

    assign sts.busy = (state_reg != TS_IDLE);
    assign sts.done = done_reg;
    assign term     = term_reg;

endmodule

/* hdl/weighted_vector_gram_accumulator_core.sv */
// Weighted vector Gram accumulator: each write is stored as it is accepted; a query runs
// over N = min(point_count, MAX_POINTS) points, each of which reads vector i, vector j and
// its weight and then runs 9 terms through the one shared multiplier before the result.
// One item is in work at a time; the result register frees the input side once loaded.
// aresetn (synchronous, active low) sets point_count to 64 and idles the sequencer;
// the vector and weight memories are not cleared and hold garbage until written.
`include "weighted_vector_gram_accumulator_core_macros.svh"

module weighted_vector_gram_accumulator_core
    import wvga_pkg::*;
#(
    parameter int MAX_DOFS   = 64,
    parameter int MAX_POINTS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration: point_count
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [PC_W-1:0]       cfg_data,
    // Input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // dof_index, other_dof, point_index, comp_x, comp_y, comp_z, weight_value, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic [OP_W-1:0]       s_tuser,
    // Result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // sum_xx, sum_yy, sum_zz, sum_xy, sum_xz, sum_yz
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int DOF_W = $clog2(MAX_DOFS);
    localparam int PT_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int BDEPTH = MAX_DOFS * MAX_POINTS;
    localparam int BA_W  = $clog2(BDEPTH);
    localparam int ACC_W = TERM_W + 1 + $clog2(MAX_POINTS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD_I  = 7'b0000010,
        S_RD_J  = 7'b0000100,
        S_LATCH = 7'b0001000,
        S_ISSUE = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    // Index wrap tables over the 6-bit input fields
    function automatic logic [DOF_W-1:0] wrap_dof(input logic [IDX_W-1:0] v);
        logic [DOF_W-1:0] r;
        r = '0;
        for (int t = 0; t < 64; t++) begin
            if (v == IDX_W'(t)) begin
                r = DOF_W'(t % MAX_DOFS);
            end
        end
        return r;
    endfunction

    function automatic logic [PT_W-1:0] wrap_pt(input logic [IDX_W-1:0] v);
        logic [PT_W-1:0] r;
        r = '0;
        for (int t = 0; t < 64; t++) begin
            if (v == IDX_W'(t)) begin
                r = PT_W'(t % MAX_POINTS);
            end
        end
        return r;
    endfunction

    // Input field unpack
    op_t                      s_op;
    logic [IDX_W-1:0]         s_dof, s_other, s_point;
    logic [VEC_W-1:0]         s_vec;
    logic [WT_W-1:0]          s_weight;
    logic                     s_accept;

    assign s_op     = op_t'(s_tuser);
    assign s_dof    = s_tdata[5:0];
    assign s_other  = s_tdata[11:6];
    assign s_point  = s_tdata[17:12];
    assign s_vec    = s_tdata[89:18];
    assign s_weight = s_tdata[113:90];
    assign s_accept = s_tvalid && s_tready;

    // Registers
    state_t                   state_reg, state_next;
    logic [PC_W-1:0]          pc_reg, pc_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [BA_W-1:0]          base_i_reg, base_i_next;
    logic [BA_W-1:0]          base_j_reg, base_j_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic [TIDX_W-1:0]        t_reg, t_next;
    logic [VEC_W-1:0]         vec_i_reg, vec_i_next;
    logic [VEC_W-1:0]         vec_j_reg, vec_j_next;
    logic [WT_W-1:0]          w_reg, w_next;
    logic signed [ACC_W-1:0]  acc_reg [NUM_SUMS];
    logic signed [ACC_W-1:0]  acc_next [NUM_SUMS];
    logic [OUT_DATA_W-1:0]    m_tdata_reg, m_tdata_next;

    // Memory ports
    logic                     basis_we, weight_we;
    logic [BA_W-1:0]          basis_waddr, basis_raddr;
    logic [VEC_W-1:0]         basis_rdata;
    logic [PT_W-1:0]          weight_waddr;
    logic [WT_W-1:0]          weight_rdata;

    // Term unit
    term_req_t                term_req;
    term_sts_t                term_sts;
    logic signed [TERM_W-1:0] term_val;
    logic [2:0]               dst;

    // Query setup values
    logic [CNT_W-1:0]         n_eff;
    logic signed [OUT_W-1:0]  sat_val [NUM_SUMS];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);

    // Write path: basis at dof * MAX_POINTS + point, weight at point
    assign basis_we     = s_accept && (s_op == OP_WR_BASIS);
    assign weight_we    = s_accept && (s_op == OP_WR_WEIGHT);
    assign weight_waddr = wrap_pt(s_point);
    assign basis_waddr  = BA_W'(BA_W'(wrap_dof(s_dof)) * BA_W'(MAX_POINTS))
                        + BA_W'(weight_waddr);

    // Read path: vector i first, vector j in the following cycle
    assign basis_raddr = ((state_reg == S_RD_J) ? base_j_reg : base_i_reg)
                       + BA_W'(k_reg[PT_W-1:0]);

    wvga_ram #(
        .WIDTH (VEC_W),
        .DEPTH (BDEPTH)
    ) u_basis_ram (
        .clk   (aclk),
        .we    (basis_we),
        .waddr (basis_waddr),
        .wdata (s_vec),
        .raddr (basis_raddr),
        .rdata (basis_rdata)
    );

    wvga_ram #(
        .WIDTH (WT_W),
        .DEPTH (MAX_POINTS)
    ) u_weight_ram (
        .clk   (aclk),
        .we    (weight_we),
        .waddr (weight_waddr),
        .wdata (s_weight),
        .raddr (k_reg[PT_W-1:0]),
        .rdata (weight_rdata)
    );

    // Term request: component pair picked by the term index
    assign term_req.valid = (state_reg == S_ISSUE);
    assign term_req.c     = vec_i_reg[term_src_i(t_reg)*COMP_W +: COMP_W];
    assign term_req.d     = vec_j_reg[term_src_j(t_reg)*COMP_W +: COMP_W];
    assign term_req.w     = w_reg;
    assign dst            = term_dst(t_reg);

    wvga_term_unit u_term (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (term_req),
        .sts     (term_sts),
        .term    (term_val)
    );

    // Point count clipped to the store depth
    always_comb begin
        if (int'(pc_reg) > MAX_POINTS) begin
            n_eff = CNT_W'(MAX_POINTS);
        end else begin
            n_eff = CNT_W'(pc_reg);
        end
    end

    // Saturate accumulators to the 40-bit result when they are wider; else sign-extend
    generate
        if (ACC_W > OUT_W) begin : g_sat
            always_comb begin
                for (int c = 0; c < NUM_SUMS; c++) begin
                    if (acc_reg[c] > ACC_W'(SAT_HI)) begin
                        sat_val[c] = SAT_HI;
                    end else if (acc_reg[c] < ACC_W'(SAT_LO)) begin
                        sat_val[c] = SAT_LO;
                    end else begin
                        sat_val[c] = OUT_W'(acc_reg[c]);
                    end
                end
            end
        end else begin : g_ext
            always_comb begin
                for (int c = 0; c < NUM_SUMS; c++) begin
                    sat_val[c] = OUT_W'(acc_reg[c]);
                end
            end
        end
    endgenerate

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        m_tvalid_next = m_tvalid_reg;
        base_i_next   = base_i_reg;
        base_j_next   = base_j_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        t_next        = t_reg;
        vec_i_next    = vec_i_reg;
        vec_j_next    = vec_j_reg;
        w_next        = w_reg;
        m_tdata_next  = m_tdata_reg;
        for (int c = 0; c < NUM_SUMS; c++) begin
            acc_next[c] = acc_reg[c];
        end

        if (cfg_valid) begin
            pc_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept && (s_op == OP_QUERY)) begin
                    base_i_next = BA_W'(BA_W'(wrap_dof(s_dof)) * BA_W'(MAX_POINTS));
                    base_j_next = BA_W'(BA_W'(wrap_dof(s_other)) * BA_W'(MAX_POINTS));
                    n_next      = n_eff;
                    k_next      = '0;
                    for (int c = 0; c < NUM_SUMS; c++) begin
                        acc_next[c] = '0;
                    end
                    state_next = (n_eff == '0) ? S_DONE : S_RD_I;
                end
            end
            S_RD_I: begin
                state_next = S_RD_J;
            end
            S_RD_J: begin
                vec_i_next = basis_rdata;
                w_next     = weight_rdata;
                state_next = S_LATCH;
            end
            S_LATCH: begin
                vec_j_next = basis_rdata;
                t_next     = '0;
                state_next = S_ISSUE;
            end
            S_ISSUE: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (term_sts.done) begin
                    acc_next[dst] = acc_reg[dst] + ACC_W'(term_val);
                    if (t_reg == TIDX_W'(N_TERMS - 1)) begin
                        if (CNT_W'(k_reg + 1'b1) == n_reg) begin
                            state_next = S_DONE;
                        end else begin
                            k_next     = CNT_W'(k_reg + 1'b1);
                            state_next = S_RD_I;
                        end
                    end else begin
                        t_next     = TIDX_W'(t_reg + 1'b1);
                        state_next = S_ISSUE;
                    end
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {sat_val[5], sat_val[4], sat_val[3],
                                     sat_val[2], sat_val[1], sat_val[0]};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pc_reg       <= PC_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        base_i_reg  <= base_i_next;
        base_j_reg  <= base_j_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        t_reg       <= t_next;
        vec_i_reg   <= vec_i_next;
        vec_j_reg   <= vec_j_next;
        w_reg       <= w_next;
        m_tdata_reg <= m_tdata_next;
        for (int c = 0; c < NUM_SUMS; c++) begin
            acc_reg[c] <= acc_next[c];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `WVGA_ASSERT_SAME(a_idle_unit_free, aclk, aresetn, state_reg == S_IDLE, !term_sts.busy, "term unit busy while sequencer idle")
    `WVGA_ASSERT_SAME(a_done_in_wait, aclk, aresetn, term_sts.done, state_reg == S_WAIT, "term finished outside the wait state")
    `WVGA_ASSERT_NEXT(a_query_blocks, aclk, aresetn, s_accept && (s_op == OP_QUERY), !s_tready, "input still ready after a query was taken")
    `WVGA_ASSERT_SAME(a_result_from_done, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg == S_DONE), "result word raised outside the done state")

endmodule
